// ===== src/rttip_pkg.sv =====
`timescale 1ns / 1ps
// Package for the radix text to integer parser: constants, radix codes,
// character codes and the classified character record. No dependencies.
package rttip_pkg;

  localparam int VALUE_BITS     = 64;
  localparam int COUNT_BITS     = 7;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] MODE_DEC = 2'd0;
  localparam logic [1:0] MODE_HEX = 2'd1;
  localparam logic [1:0] MODE_BIN = 2'd2;
  localparam logic [1:0] MODE_OCT = 2'd3;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_1     = 8'h31;
  localparam logic [7:0] CHAR_7     = 8'h37;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UB    = 8'h42;
  localparam logic [7:0] CHAR_LB    = 8'h62;
  localparam logic [7:0] CHAR_UX    = 8'h58;
  localparam logic [7:0] CHAR_LX    = 8'h78;

  typedef struct packed {
    logic       is_end;
    logic       white;
    logic       zero;
    logic       prefix;
    logic       digit_ok;
    logic [3:0] digit;
    logic [1:0] mode;
  } entry_t;

endpackage

// ===== src/rttip_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for characters, results and the mode write.
// Depends on nothing.
interface rttip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_end;
  modport source (output valid, ch, is_end, input ready);
  modport sink (input valid, ch, is_end, output ready);
endinterface

interface rttip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        ok;
  modport source (output valid, value, ok, input ready);
  modport sink (input valid, value, ok, output ready);
endinterface

interface rttip_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/rttip_front.sv =====
`timescale 1ns / 1ps
// Front end: holds the radix mode register and classifies each character.
// Depends on rttip_pkg and rttip_if.
module rttip_front (
  input  logic              clk,
  input  logic              rst,
  rttip_cfg_if.sink         cfg,
  rttip_in_if.sink          chars,
  output rttip_pkg::entry_t push_entry,
  output logic              push_valid,
  input  logic              push_ready
);
  import rttip_pkg::*;

  logic [1:0] radix_mode;
  logic [7:0] c;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_mode <= MODE_DEC;
    end else if (cfg.valid && cfg.ready) begin
      radix_mode <= cfg.data;
    end
  end

  assign c           = chars.ch;
  assign push_valid  = chars.valid;
  assign chars.ready = push_ready;

  always_comb begin
    push_entry        = '0;
    push_entry.is_end = chars.is_end;
    push_entry.mode   = radix_mode;
    push_entry.white  = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    push_entry.zero   = (c == CHAR_0);
    push_entry.prefix = ((radix_mode == MODE_HEX) && (c == CHAR_LX || c == CHAR_UX)) ||
                        ((radix_mode == MODE_BIN) && (c == CHAR_LB || c == CHAR_UB));
    case (radix_mode)
      MODE_DEC: begin
        push_entry.digit_ok = (c >= CHAR_0 && c <= CHAR_9);
        push_entry.digit    = 4'(c - CHAR_0);
      end
      MODE_HEX: begin
        if (c >= CHAR_0 && c <= CHAR_9) begin
          push_entry.digit_ok = 1'b1;
          push_entry.digit    = 4'(c - CHAR_0);
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
          push_entry.digit_ok = 1'b1;
          push_entry.digit    = 4'(c - CHAR_LA + 8'd10);
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
          push_entry.digit_ok = 1'b1;
          push_entry.digit    = 4'(c - CHAR_UA + 8'd10);
        end
      end
      MODE_BIN: begin
        push_entry.digit_ok = (c == CHAR_0 || c == CHAR_1);
        push_entry.digit    = 4'(c - CHAR_0);
      end
      default: begin
        push_entry.digit_ok = (c >= CHAR_0 && c <= CHAR_7);
        push_entry.digit    = 4'(c - CHAR_0);
      end
    endcase
  end

endmodule

// ===== src/rttip_queue.sv =====
`timescale 1ns / 1ps
// Short first-in first-out queue of classified characters between the
// front and back ends. Depends on rttip_pkg.
module rttip_queue (
  input  logic              clk,
  input  logic              rst,
  input  rttip_pkg::entry_t push_entry,
  input  logic              push_valid,
  output logic              push_ready,
  output rttip_pkg::entry_t head,
  output logic              pop_valid,
  input  logic              pop_ready
);
  import rttip_pkg::*;

  entry_t                    slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;
  logic                      push;
  logic                      pop;

  assign push_ready = (count != QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign head       = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/rttip_back.sv =====
`timescale 1ns / 1ps
// Back end: parse state, digit accumulation with overflow checks and the
// result register. Depends on rttip_pkg and rttip_if.
module rttip_back (
  input  logic              clk,
  input  logic              rst,
  input  rttip_pkg::entry_t head,
  input  logic              pop_valid,
  output logic              pop_ready,
  rttip_out_if.source       result
);
  import rttip_pkg::*;

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_PREFIX = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  logic [1:0]            phase;
  logic [1:0]            phase_next;
  logic [VALUE_BITS-1:0] accumulator;
  logic [VALUE_BITS-1:0] accumulator_next;
  logic [COUNT_BITS-1:0] digit_count;
  logic [COUNT_BITS-1:0] digit_count_next;
  logic                  failed;
  logic                  failed_next;
  logic                  out_valid;
  logic [63:0]           res_value;
  logic                  out_ok;

  logic                  pop;
  logic                  end_ok;
  logic [VALUE_BITS+3:0] dec_sum;
  logic [VALUE_BITS-1:0] dig_acc;
  logic                  dig_ovf;
  logic [COUNT_BITS-1:0] count_inc;

  assign pop_ready    = !head.is_end || !out_valid || result.ready;
  assign pop          = pop_valid && pop_ready;
  assign end_ok       = !failed && (phase == PH_ZERO || phase == PH_DIGITS);
  assign result.valid = out_valid;
  assign result.value = res_value;
  assign result.ok    = out_ok;

  assign dec_sum   = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0} +
                     {{VALUE_BITS{1'b0}}, head.digit};
  assign count_inc = (digit_count == '1) ? digit_count : digit_count + 1'b1;

  always_comb begin
    case (head.mode)
      MODE_DEC: begin
        dig_acc = dec_sum[VALUE_BITS-1:0];
        dig_ovf = (dec_sum[VALUE_BITS+3:VALUE_BITS] != '0);
      end
      MODE_HEX: begin
        dig_acc = {accumulator[VALUE_BITS-5:0], head.digit};
        dig_ovf = (accumulator[VALUE_BITS-1 -: 4] != '0);
      end
      MODE_BIN: begin
        dig_acc = {accumulator[VALUE_BITS-2:0], head.digit[0]};
        dig_ovf = (digit_count >= COUNT_BITS'(VALUE_BITS));
      end
      default: begin
        dig_acc = {accumulator[VALUE_BITS-4:0], head.digit[2:0]};
        dig_ovf = (accumulator[VALUE_BITS-1 -: 3] != '0);
      end
    endcase
  end

  always_comb begin
    phase_next       = phase;
    accumulator_next = accumulator;
    digit_count_next = digit_count;
    failed_next      = failed;
    if (pop) begin
      if (head.is_end) begin
        phase_next       = PH_SKIP;
        accumulator_next = '0;
        digit_count_next = '0;
        failed_next      = 1'b0;
      end else if (!failed) begin
        if (phase == PH_SKIP && head.white) begin
          phase_next = PH_SKIP;
        end else if (phase == PH_SKIP && head.zero) begin
          phase_next       = PH_ZERO;
          accumulator_next = '0;
          digit_count_next = COUNT_BITS'(1);
        end else if (phase == PH_ZERO && head.prefix) begin
          phase_next       = PH_PREFIX;
          accumulator_next = '0;
          digit_count_next = '0;
        end else if (!head.digit_ok || dig_ovf) begin
          failed_next = 1'b1;
        end else begin
          phase_next       = PH_DIGITS;
          accumulator_next = dig_acc;
          digit_count_next = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      accumulator <= '0;
      digit_count <= '0;
      failed      <= 1'b0;
    end else begin
      phase       <= phase_next;
      accumulator <= accumulator_next;
      digit_count <= digit_count_next;
      failed      <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.is_end) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.is_end) begin
      res_value <= end_ok ? 64'(accumulator) : 64'd0;
      out_ok    <= end_ok;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ok |-> res_value == 64'd0)
    else $error("failed result carries a non-zero value");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    pop && head.is_end |=> phase == PH_SKIP && !failed && digit_count == '0)
    else $error("parse state not cleared after end marker");

  a_prefix_state: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PREFIX |-> accumulator == '0 && digit_count == '0)
    else $error("prefix phase with stale accumulator or count");

  a_zero_state: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ZERO |-> accumulator == '0 && digit_count == COUNT_BITS'(1))
    else $error("leading zero phase with wrong accumulator or count");

endmodule

// ===== src/radix_text_to_integer_parser.sv =====
`timescale 1ns / 1ps
// Streaming ASCII number parser. Throughput is one character or end marker per
// cycle unless the queue is full or a waiting result holds back an end marker,
// set by the back end's digit update (times ten as a shift-add and one wide
// compare). A character enters a queue slot at its transfer and is applied when
// popped; popping the end marker loads the result. Synchronous reset clears the
// parse state, queue and result valid flag, and sets the radix mode to decimal.
module radix_text_to_integer_parser (
  input  logic         clk,
  input  logic         rst,
  rttip_cfg_if.sink    cfg,
  rttip_in_if.sink     chars,
  rttip_out_if.source  result
);
  import rttip_pkg::*;

  entry_t push_entry;
  logic   push_valid;
  logic   push_ready;
  entry_t head;
  logic   pop_valid;
  logic   pop_ready;

  rttip_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .chars      (chars),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  rttip_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head       (head),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  rttip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .result    (result)
  );

endmodule
